FILE: rtl/core/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

    localparam int unsigned HDR_BYTES = 8;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_NO_FIT = 2'd2
    } t_ffha_status;

    typedef enum logic [1:0] {
        RD_HEAD = 2'd0,
        RD_CUR  = 2'd1,
        RD_NEXT = 2'd2,
        RD_BLK  = 2'd3
    } t_rd_sel;

    // controller to datapath
    typedef struct packed {
        logic         ld_req;
        logic         init_wr;
        logic         rd_en;
        t_rd_sel      rd_sel;
        logic         a_split_wr;
        logic         a_link_split;
        logic         a_link_whole;
        logic         a_advance;
        logic         ld_sz;
        logic         f_step;
        logic         f_wr_blk;
        logic         f_wr_prev;
        logic         out_load;
        t_ffha_status res_code;
        logic         res_addr_en;
    } t_ffha_ctl;

    // datapath to controller
    typedef struct packed {
        logic head_end;
        logic fits;
        logic split;
        logic nx_end;
        logic blk_bad;
        logic sz_bad;
        logic walk_more;
        logic overlap;
        logic cur_in;
    } t_ffha_stat;

endpackage

FILE: rtl/core/first_fit_heap_allocator_core.sv
// top level of the first-fit heap allocator: sequencer plus datapath
//
// manages a heap of HEAP_BYTES bytes as an address-ordered free list with
// an 8-byte header (size, next) at the start of every block
// input channel s_axis: one item is one request; tuser carries the command
// (allocate or free), tdata carries the requested payload size and the
// payload offset to free
// output channel m_axis: exactly one item per request, in request order;
// tuser carries the status, tdata the payload offset (zero on failure/free)
// timing: one request is worked at a time; the headers sit in a single-port
// read memory, so the walk reads one header at a time: free blocks in list
// order on an allocate, the blocks before the freed one on a free
// allocate: no block is inspected when the list is empty, and a block that
// splits takes an extra link step before the result
// free: a rejected request goes to the result without finishing the walk;
// the sequencer takes the next request once each result is loaded
// a finished item waits in the output register while the next request is
// taken; a stalled receiver holds the sequencer in its final step until the
// output register frees up
// reset: the first step after reset writes the initial whole-heap header, then
// s_axis_tready rises
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // req_size[8:0], free_addr[16:9], zero pad
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // payload_addr[7:0]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import ffha_pkg::*;

    t_ffha_ctl  ctl;
    t_ffha_stat stat;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    // header memories, list pointers and the result register
    ffha_datapath #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_req_size     (s_axis_tdata[8:0]),
        .i_free_addr    (s_axis_tdata[16:9]),
        .o_stat         (stat),
        .o_status       (m_axis_tuser),
        .o_payload_addr (m_axis_tdata)
    );

endmodule

FILE: rtl/core/ffha_datapath.sv
// header memories, list pointers and arithmetic of the allocator
module ffha_datapath #(
    parameter int HEAP_BYTES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffha_pkg::t_ffha_ctl   i_ctl,
    input  logic [8:0]            i_req_size,
    input  logic [7:0]            i_free_addr,
    output ffha_pkg::t_ffha_stat  o_stat,
    output logic [1:0]            o_status,
    output logic [7:0]            o_payload_addr
);
    import ffha_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES + 1);
    localparam int IW = $clog2(HEAP_BYTES);
    localparam int XW = ((AW > 10) ? AW : 10) + 1;
    localparam logic [AW-1:0] END_MARK = AW'(HEAP_BYTES);
    localparam logic [XW-1:0] HEAP_X   = XW'(HEAP_BYTES);
    localparam logic [XW-1:0] HDR_X    = XW'(HDR_BYTES);

    logic [AW-1:0] mem_size [HEAP_BYTES];
    logic [AW-1:0] mem_next [HEAP_BYTES];

    logic [AW-1:0] r_head, r_cur, r_prev, r_prev_sz, r_sz;
    logic          r_has_prev;
    logic [9:0]    r_need;
    logic [7:0]    r_fa;
    logic [AW-1:0] r_rd_size, r_rd_next;
    logic [1:0]    r_out_status;
    logic [7:0]    r_out_addr;

    logic [XW-1:0] cur_x, need_x, rdsz_x, b_x, sz_x, prev_end_x, rem_x, pay_x;
    logic [AW-1:0] blk, rem, cur_e, b_size_new, b_next_new;
    logic          cur_in, merge_r, merge_l;
    logic [AW-1:0] rd_addr;
    logic          sz_we, nx_we;
    logic [AW-1:0] sz_wa, sz_wd, nx_wa, nx_wd;

    assign cur_x      = XW'(r_cur);
    assign need_x     = XW'(r_need);
    assign rdsz_x     = XW'(r_rd_size);
    assign b_x        = XW'(r_fa) - HDR_X;
    assign sz_x       = XW'(r_sz);
    assign prev_end_x = XW'(r_prev) + XW'(r_prev_sz);
    assign rem_x      = cur_x + need_x;
    assign pay_x      = cur_x + HDR_X;
    assign blk        = b_x[AW-1:0];
    assign rem        = rem_x[AW-1:0];
    assign cur_in     = r_cur < END_MARK;
    assign cur_e      = cur_in ? r_cur : END_MARK;
    assign merge_r    = cur_in && (b_x + sz_x == cur_x);
    assign merge_l    = r_has_prev && (prev_end_x == b_x);
    assign b_size_new = merge_r ? (r_sz + r_rd_size) : r_sz;
    assign b_next_new = merge_r ? r_rd_next : cur_e;

    always_comb begin
        o_stat.head_end  = r_head >= END_MARK;
        o_stat.fits      = rdsz_x >= need_x;
        o_stat.split     = (rdsz_x - need_x) > HDR_X;
        o_stat.nx_end    = r_rd_next >= END_MARK;
        o_stat.blk_bad   = (r_fa < 8'(HDR_BYTES)) || (b_x >= HEAP_X);
        o_stat.sz_bad    = (rdsz_x < HDR_X) || (rdsz_x + b_x > HEAP_X);
        o_stat.walk_more = cur_in && (cur_x < b_x);
        o_stat.overlap   = (r_has_prev && (prev_end_x > b_x)) ||
                           (cur_in && (b_x + sz_x > cur_x));
        o_stat.cur_in    = cur_in;
    end

    always_comb begin
        case (i_ctl.rd_sel)
            RD_HEAD: rd_addr = r_head;
            RD_CUR:  rd_addr = r_cur;
            RD_NEXT: rd_addr = r_rd_next;
            RD_BLK:  rd_addr = blk;
            default: rd_addr = r_cur;
        endcase
    end

    // write ports of the two header memories
    always_comb begin
        sz_we = 1'b0;
        sz_wa = '0;
        sz_wd = '0;
        nx_we = 1'b0;
        nx_wa = '0;
        nx_wd = '0;
        if (i_ctl.init_wr) begin
            sz_we = 1'b1;
            sz_wd = END_MARK;
            nx_we = 1'b1;
            nx_wd = END_MARK;
        end else if (i_ctl.a_split_wr) begin
            sz_we = 1'b1;
            sz_wa = rem;
            sz_wd = AW'(rdsz_x - need_x);
            nx_we = 1'b1;
            nx_wa = rem;
            nx_wd = r_rd_next;
        end else if (i_ctl.a_link_split) begin
            sz_we = 1'b1;
            sz_wa = r_cur;
            sz_wd = r_need[AW-1:0] & {AW{1'b1}};
            nx_we = r_has_prev;
            nx_wa = r_prev;
            nx_wd = rem;
        end else if (i_ctl.a_link_whole) begin
            nx_we = r_has_prev;
            nx_wa = r_prev;
            nx_wd = r_rd_next;
        end else if (i_ctl.f_wr_blk) begin
            sz_we = 1'b1;
            sz_wa = blk;
            sz_wd = b_size_new;
            nx_we = 1'b1;
            nx_wa = blk;
            nx_wd = b_next_new;
        end else if (i_ctl.f_wr_prev) begin
            sz_we = merge_l;
            sz_wa = r_prev;
            sz_wd = r_prev_sz + b_size_new;
            nx_we = r_has_prev;
            nx_wa = r_prev;
            nx_wd = merge_l ? b_next_new : blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sz_we) begin
            mem_size[sz_wa[IW-1:0]] <= sz_wd;
        end
        if (nx_we) begin
            mem_next[nx_wa[IW-1:0]] <= nx_wd;
        end
        if (i_ctl.rd_en) begin
            r_rd_size <= mem_size[rd_addr[IW-1:0]];
            r_rd_next <= mem_next[rd_addr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_ctl.init_wr) begin
            r_head <= '0;
        end else if (i_ctl.a_link_split && !r_has_prev) begin
            r_head <= rem;
        end else if (i_ctl.a_link_whole && !r_has_prev) begin
            r_head <= r_rd_next;
        end else if (i_ctl.f_wr_prev && !r_has_prev) begin
            r_head <= blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_req) begin
            r_need     <= {1'b0, i_req_size} + 10'(HDR_BYTES);
            r_fa       <= i_free_addr;
            r_cur      <= r_head;
            r_has_prev <= 1'b0;
        end else if (i_ctl.a_advance || i_ctl.f_step) begin
            r_prev     <= r_cur;
            r_prev_sz  <= r_rd_size;
            r_has_prev <= 1'b1;
            r_cur      <= r_rd_next;
        end
        if (i_ctl.ld_sz) begin
            r_sz <= r_rd_size;
        end
        if (i_ctl.out_load) begin
            r_out_status <= i_ctl.res_code;
            r_out_addr   <= i_ctl.res_addr_en ? pay_x[7:0] : 8'd0;
        end
    end

    assign o_status       = r_out_status;
    assign o_payload_addr = r_out_addr;

endmodule

FILE: rtl/core/ffha_ctrl.sv
// sequencer of the allocator: list walk, split, link and coalesce steps
module ffha_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  ffha_pkg::t_ffha_stat  i_stat,
    output ffha_pkg::t_ffha_ctl   o_ctl
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_CHK, S_A_LINK, S_F_START, S_F_CHKB,
        S_F_WALK, S_F_STEP, S_F_WB, S_F_WP, S_DONE
    } t_state;

    t_state       r_state, n_state;
    logic         r_out_valid, n_out_valid;
    t_ffha_status r_code, n_code;
    logic         r_addr_en, n_addr_en;

    always_comb begin
        o_ctl       = '0;
        o_ctl.rd_sel = RD_CUR;
        o_ctl.res_code = r_code;
        o_ctl.res_addr_en = r_addr_en;
        n_state     = r_state;
        n_code      = r_code;
        n_addr_en   = r_addr_en;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        case (r_state)
            S_INIT: begin
                o_ctl.init_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.ld_req = 1'b1;
                    n_code    = ST_OK;
                    n_addr_en = 1'b0;
                    if (i_in_cmd == CMD_FREE) begin
                        n_state = S_F_START;
                    end else if (i_stat.head_end) begin
                        n_code  = ST_EMPTY;
                        n_state = S_DONE;
                    end else begin
                        o_ctl.rd_en  = 1'b1;
                        o_ctl.rd_sel = RD_HEAD;
                        n_state = S_A_CHK;
                    end
                end
            end
            S_A_CHK: begin
                if (i_stat.fits) begin
                    n_addr_en = 1'b1;
                    if (i_stat.split) begin
                        o_ctl.a_split_wr = 1'b1;
                        n_state = S_A_LINK;
                    end else begin
                        o_ctl.a_link_whole = 1'b1;
                        n_state = S_DONE;
                    end
                end else if (i_stat.nx_end) begin
                    n_code  = ST_NO_FIT;
                    n_state = S_DONE;
                end else begin
                    o_ctl.a_advance = 1'b1;
                    o_ctl.rd_en     = 1'b1;
                    o_ctl.rd_sel    = RD_NEXT;
                end
            end
            S_A_LINK: begin
                o_ctl.a_link_split = 1'b1;
                n_state = S_DONE;
            end
            S_F_START: begin
                if (i_stat.blk_bad) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_BLK;
                    n_state = S_F_CHKB;
                end
            end
            S_F_CHKB: begin
                o_ctl.ld_sz = 1'b1;
                n_state = i_stat.sz_bad ? S_DONE : S_F_WALK;
            end
            S_F_WALK: begin
                if (i_stat.walk_more) begin
                    o_ctl.rd_en = 1'b1;
                    n_state = S_F_STEP;
                end else if (i_stat.overlap) begin
                    n_state = S_DONE;
                end else begin
                    // right neighbour header is needed for a merge
                    o_ctl.rd_en = i_stat.cur_in;
                    n_state = S_F_WB;
                end
            end
            S_F_STEP: begin
                o_ctl.f_step = 1'b1;
                n_state = S_F_WALK;
            end
            S_F_WB: begin
                o_ctl.f_wr_blk = 1'b1;
                n_state = S_F_WP;
            end
            S_F_WP: begin
                o_ctl.f_wr_prev = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
            r_code      <= ST_OK;
            r_addr_en   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_code      <= n_code;
            r_addr_en   <= n_addr_en;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
